>>> design/ecm_rx_pkg.sv
package ecm_rx_pkg;

    // Default sizing
    localparam int FRAME_CAPACITY_DEF = 2048;
    localparam int MAX_PACKET_DEF     = 64;

    // Fixed field widths
    localparam int ACTION_W = 3;
    localparam int BYTE_W   = 8;
    localparam int IDX_W    = 11;
    localparam int STATUS_W = 4;
    localparam int LEN_W    = 12;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PKT_BYTE = 3'd0,
        ACT_PKT_END  = 3'd1,
        ACT_READ     = 3'd2,
        ACT_RELEASE  = 3'd3,
        ACT_RESET    = 3'd4
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_CONTINUE    = 4'd0,
        ST_FRAME_READY = 4'd1,
        ST_DROPPED     = 4'd2,
        ST_REJECTED    = 4'd3,
        ST_RELEASED    = 4'd4,
        ST_REL_IGNORED = 4'd5,
        ST_READ_OK     = 4'd6,
        ST_READ_BAD    = 4'd7,
        ST_RESET       = 4'd8
    } t_status;

    // Result of one request, minus the byte that the store returns from its registered read port
    typedef struct packed {
        t_status          status;
        logic             ep_accepting;
        logic             frame_ready;
        logic [LEN_W-1:0] frame_length;
        logic             is_read;
    } t_result;

endpackage

>>> design/ecm_rx_store.sv
module ecm_rx_store
    import ecm_rx_pkg::*;
#(
    parameter int FRAME_CAPACITY = FRAME_CAPACITY_DEF,
    localparam int AW = $clog2(FRAME_CAPACITY)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [BYTE_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [AW-1:0]     i_rd_addr,
    output logic [BYTE_W-1:0] o_rd_data
);

    logic [BYTE_W-1:0] mem [FRAME_CAPACITY];
    logic [BYTE_W-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port; data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> design/ecm_rx_ctrl.sv
module ecm_rx_ctrl
    import ecm_rx_pkg::*;
#(
    parameter int FRAME_CAPACITY = FRAME_CAPACITY_DEF,
    parameter int MAX_PACKET     = MAX_PACKET_DEF,
    localparam int AW = $clog2(FRAME_CAPACITY)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic                i_cfg_wr_data,
    input  logic                i_accept,
    input  logic [ACTION_W-1:0] i_action,
    input  logic [BYTE_W-1:0]   i_data_byte,
    input  logic [IDX_W-1:0]    i_read_index,
    output logic                o_wr_en,
    output logic [AW-1:0]       o_wr_addr,
    output logic [BYTE_W-1:0]   o_wr_data,
    output logic                o_rd_en,
    output logic [AW-1:0]       o_rd_addr,
    output t_result             o_result
);

    localparam int OW  = $clog2(FRAME_CAPACITY + 1);
    localparam int PW  = $clog2(MAX_PACKET + 1);
    localparam int XIW = (OW > IDX_W) ? OW : IDX_W;
    localparam int XLW = (OW > LEN_W) ? OW : LEN_W;

    logic [OW-1:0] r_off, n_off;
    logic [OW-1:0] r_pub, n_pub;
    logic [PW-1:0] r_cnt, n_cnt;
    logic          r_drop, n_drop;
    logic          r_ready, n_ready;
    logic          r_armed, n_armed;
    logic          r_ifen;

    logic [OW:0]    sum;
    logic           fits;
    logic           short_pkt;
    logic [XIW-1:0] idx_x;
    logic           rd_ok;
    logic [XLW-1:0] len_x;
    logic           pe_drop;
    logic [OW-1:0]  pe_off;
    t_status        status;

    // Config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ifen <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_ifen <= i_cfg_wr_data;
        end
    end

    // Shared offset adder: store position for bytes, new offset at packet end
    assign sum       = (OW+1)'(r_off) + (OW+1)'(r_cnt);
    assign fits      = (sum <= (OW+1)'(FRAME_CAPACITY));
    assign short_pkt = (r_cnt < PW'(MAX_PACKET));
    assign idx_x     = XIW'(i_read_index);
    assign rd_ok     = r_ready && (idx_x < XIW'(r_pub)) && (idx_x < XIW'(FRAME_CAPACITY));

    // Packet end: append the packet or enter drop mode
    always_comb begin
        pe_drop = r_drop;
        pe_off  = r_off;
        if (!r_drop) begin
            if (fits) begin
                pe_off = sum[OW-1:0];
            end else begin
                pe_drop = 1'b1;
            end
        end
    end

    // Next state and result for the request at the input
    always_comb begin
        n_off     = r_off;
        n_pub     = r_pub;
        n_cnt     = r_cnt;
        n_drop    = r_drop;
        n_ready   = r_ready;
        n_armed   = r_armed;
        status    = ST_CONTINUE;
        o_wr_en   = 1'b0;
        o_rd_en   = 1'b0;
        case (t_action'(i_action))
            ACT_PKT_BYTE: begin
                if (short_pkt) begin
                    o_wr_en = i_accept && !r_ready && !r_drop
                              && (sum < (OW+1)'(FRAME_CAPACITY));
                    n_cnt = r_cnt + PW'(1);
                end
            end
            ACT_PKT_END: begin
                n_cnt = '0;
                if (r_ready) begin
                    n_armed = 1'b0;
                    status  = ST_REJECTED;
                end else begin
                    n_drop  = pe_drop;
                    n_off   = pe_off;
                    n_armed = 1'b1;
                    if (short_pkt && pe_drop) begin
                        n_off  = '0;
                        n_drop = 1'b0;
                        status = ST_DROPPED;
                    end else if (short_pkt && pe_off != '0) begin
                        n_pub   = pe_off;
                        n_off   = '0;
                        n_ready = 1'b1;
                        n_armed = 1'b0;
                        status  = ST_FRAME_READY;
                    end
                end
            end
            ACT_READ: begin
                o_rd_en = i_accept && rd_ok;
                status  = rd_ok ? ST_READ_OK : ST_READ_BAD;
            end
            ACT_RELEASE: begin
                if (!r_ready) begin
                    status = ST_REL_IGNORED;
                end else begin
                    n_pub   = '0;
                    n_ready = 1'b0;
                    if (r_ifen) begin
                        n_armed = 1'b1;
                    end
                    status = ST_RELEASED;
                end
            end
            ACT_RESET: begin
                n_off   = '0;
                n_pub   = '0;
                n_cnt   = '0;
                n_drop  = 1'b0;
                n_ready = 1'b0;
                n_armed = r_ifen;
                status  = ST_RESET;
            end
            default: begin
                status = ST_CONTINUE;
            end
        endcase
    end

    assign o_wr_addr = sum[AW-1:0];
    assign o_wr_data = i_data_byte;
    assign o_rd_addr = idx_x[AW-1:0];

    // Result fields reflect state after the update
    assign len_x                 = n_ready ? XLW'(n_pub) : '0;
    assign o_result.status       = status;
    assign o_result.ep_accepting = n_armed;
    assign o_result.frame_ready  = n_ready;
    assign o_result.frame_length = len_x[LEN_W-1:0];
    assign o_result.is_read      = (status == ST_READ_OK);

    // Receive state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off   <= '0;
            r_pub   <= '0;
            r_cnt   <= '0;
            r_drop  <= 1'b0;
            r_ready <= 1'b0;
            r_armed <= 1'b0;
        end else if (i_accept) begin
            r_off   <= n_off;
            r_pub   <= n_pub;
            r_cnt   <= n_cnt;
            r_drop  <= n_drop;
            r_ready <= n_ready;
            r_armed <= n_armed;
        end
    end

endmodule

>>> design/usb_ecm_rx_frame_reassembler_core.sv
// USB CDC-ECM receive frame reassembler.
// Input channel (i_in_valid / o_in_ready) carries one request: a packet byte,
// a packet end, a frame byte read, a frame release or a state reset. Every
// accepted request produces exactly one result on the output channel
// (o_out_valid / i_out_ready): status, endpoint armed flag, frame ready flag,
// published frame length and the byte read.
// The single config register, interface_enabled, is written through
// i_cfg_wr_en / i_cfg_wr_data. The user must write it only while no
// request is in flight; the block itself does not enforce this.
// A result passes from the controller through the stage register, where the
// registered read data of the frame store joins it, to the output register.
// Throughput: one request per cycle while o_in_ready stays high; store write,
// offset update and state update all complete in the accept cycle.
// A stalled receiver is absorbed by a two-deep result path (stage register
// plus output register); o_in_ready drops only when both are full.
// Reset (i_rst_n low, synchronous) clears receive state, arms nothing and
// clears interface_enabled. Frame store contents are not cleared; only
// bytes of the published frame are ever read back.
module usb_ecm_rx_frame_reassembler_core
    import ecm_rx_pkg::*;
#(
    parameter int FRAME_CAPACITY = FRAME_CAPACITY_DEF,
    parameter int MAX_PACKET     = MAX_PACKET_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic                i_cfg_wr_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [ACTION_W-1:0] i_action,
    input  logic [BYTE_W-1:0]   i_data_byte,
    input  logic [IDX_W-1:0]    i_read_index,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic                o_endpoint_accepting,
    output logic                o_frame_ready,
    output logic [LEN_W-1:0]    o_frame_length,
    output logic [BYTE_W-1:0]   o_read_data
);

    localparam int AW = $clog2(FRAME_CAPACITY);

    logic              accept;
    logic              s1_adv;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [BYTE_W-1:0] rd_data;
    t_result           result;

    logic              r_s1_valid;
    t_result           r_s1;
    logic              r_out_valid;
    t_result           r_out;
    logic [BYTE_W-1:0] r_out_data;

    // Handshake
    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    ecm_rx_ctrl #(
        .FRAME_CAPACITY (FRAME_CAPACITY),
        .MAX_PACKET     (MAX_PACKET)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (accept),
        .i_action      (i_action),
        .i_data_byte   (i_data_byte),
        .i_read_index  (i_read_index),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data),
        .o_rd_en       (rd_en),
        .o_rd_addr     (rd_addr),
        .o_result      (result)
    );

    ecm_rx_store #(
        .FRAME_CAPACITY (FRAME_CAPACITY)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Stage 1: result waits here for the store read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= result;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out      <= r_s1;
            r_out_data <= r_s1.is_read ? rd_data : '0;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_status             = r_out.status;
    assign o_endpoint_accepting = r_out.ep_accepting;
    assign o_frame_ready        = r_out.frame_ready;
    assign o_frame_length       = r_out.frame_length;
    assign o_read_data          = r_out_data;

endmodule

>>> tb/testbench.sv
module testbench;
    import ecm_rx_pkg::*;

    localparam int CAPACITY    = FRAME_CAPACITY_DEF;
    localparam int MAX_PKT     = MAX_PACKET_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_REQS = 230;

    // Action codes the block does not decode
    localparam logic [ACTION_W-1:0] ACT_SPARE_5 = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [BYTE_W-1:0]   data;
        logic [IDX_W-1:0]    idx;
    } rx_req_t;

    typedef struct packed {
        t_status           status;
        logic              ep;
        logic              rdy;
        logic [LEN_W-1:0]  len;
        logic [BYTE_W-1:0] rdata;
    } rx_result_t;

    logic    clk         = 1'b0;
    logic    rst_n       = 1'b0;
    logic    cfg_wr_en   = 1'b0;
    logic    cfg_wr_data = 1'b0;
    logic    in_valid    = 1'b0;
    logic    out_ready   = 1'b0;
    rx_req_t cur_req     = '0;

    logic                in_ready;
    logic                out_valid;
    logic [STATUS_W-1:0] status;
    logic                ep_accepting;
    logic                frame_ready;
    logic [LEN_W-1:0]    frame_length;
    logic [BYTE_W-1:0]   read_data;

    rx_req_t    pending_reqs[$];
    rx_result_t expected_results[$];
    int         mismatches  = 0;
    int         cycle_count = 0;
    int         reqs_made   = 0;
    int         burst_left  = 0;
    int         gap_left    = 0;
    bit         fetch;

    // Generator view: a packet has bytes but no end yet
    bit pkt_open       = 1'b0;
    int last_frame_len = 0;

    // Shadow of the receive state
    logic [BYTE_W-1:0] stash [CAPACITY] = '{default: '0};
    int fill_off  = 0;
    int pub_len   = 0;
    int pkt_bytes = 0;
    bit dropping  = 1'b0;
    bit frame_pub = 1'b0;
    bit ep_armed  = 1'b0;
    bit iface_en  = 1'b0;

    usb_ecm_rx_frame_reassembler_core DUT (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_cfg_wr_en          (cfg_wr_en),
        .i_cfg_wr_data        (cfg_wr_data),
        .i_in_valid           (in_valid),
        .o_in_ready           (in_ready),
        .i_action             (cur_req.action),
        .i_data_byte          (cur_req.data),
        .i_read_index         (cur_req.idx),
        .o_out_valid          (out_valid),
        .i_out_ready          (out_ready),
        .o_status             (status),
        .o_endpoint_accepting (ep_accepting),
        .o_frame_ready        (frame_ready),
        .o_frame_length       (frame_length),
        .o_read_data          (read_data)
    );

    always #6 clk = ~clk;

    // Apply one request to the shadow state and return what the block must answer
    function automatic rx_result_t reassembler_step(input rx_req_t r);
        rx_result_t res;
        int         pos;
        int         plen;
        res.status = ST_CONTINUE;
        res.rdata  = '0;
        case (r.action)
            ACT_PKT_BYTE: begin
                // bytes past the max packet size are dropped on the floor
                if (pkt_bytes < MAX_PKT) begin
                    pos = fill_off + pkt_bytes;
                    if (!frame_pub && !dropping && pos < CAPACITY)
                        stash[pos] = r.data;
                    pkt_bytes++;
                end
            end
            ACT_PKT_END: begin
                plen      = pkt_bytes;
                pkt_bytes = 0;
                if (frame_pub) begin
                    // frame still held by the consumer: NAK
                    ep_armed   = 1'b0;
                    res.status = ST_REJECTED;
                end else begin
                    if (!dropping) begin
                        if (plen <= CAPACITY - fill_off)
                            fill_off += plen;
                        else
                            dropping = 1'b1;
                    end
                    ep_armed = 1'b1;
                    if (plen < MAX_PKT && dropping) begin
                        fill_off   = 0;
                        dropping   = 1'b0;
                        res.status = ST_DROPPED;
                    end else if (plen < MAX_PKT && fill_off != 0) begin
                        pub_len    = fill_off;
                        fill_off   = 0;
                        frame_pub  = 1'b1;
                        ep_armed   = 1'b0;
                        res.status = ST_FRAME_READY;
                    end
                end
            end
            ACT_READ: begin
                if (frame_pub && r.idx < pub_len) begin
                    res.rdata  = stash[r.idx];
                    res.status = ST_READ_OK;
                end else begin
                    res.status = ST_READ_BAD;
                end
            end
            ACT_RELEASE: begin
                if (!frame_pub) begin
                    res.status = ST_REL_IGNORED;
                end else begin
                    pub_len   = 0;
                    frame_pub = 1'b0;
                    if (iface_en)
                        ep_armed = 1'b1;
                    res.status = ST_RELEASED;
                end
            end
            ACT_RESET: begin
                fill_off   = 0;
                pub_len    = 0;
                pkt_bytes  = 0;
                dropping   = 1'b0;
                frame_pub  = 1'b0;
                ep_armed   = iface_en;
                res.status = ST_RESET;
            end
            default: ;
        endcase
        res.ep  = ep_armed;
        res.rdy = frame_pub;
        res.len = frame_pub ? LEN_W'(pub_len) : '0;
        return res;
    endfunction

    function automatic void log_failure(input string msg);
        if (mismatches < 10)
            $display("[%0t] %s", $time, msg);
        mismatches++;
    endfunction

    function automatic void check_field(input string fname, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
            log_failure($sformatf("%s mismatch: expected %0d, got %0d", fname, want, got));
    endfunction

    // Cycle count and run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Driver: bursts of requests separated by random gaps
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            fetch = !in_valid;
            if (in_valid && in_ready) begin
                expected_results.push_back(reassembler_step(cur_req));
                fetch = 1'b1;
            end
            if (fetch) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    cur_req  <= pending_reqs.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver back-pressure: cycles through free, light, heavy and periodic stalls
    always @(posedge clk) begin
        case (cycle_count[9:8])
            2'd0:    out_ready <= 1'b1;
            2'd1:    out_ready <= ($urandom_range(0, 3) != 0);
            2'd2:    out_ready <= ($urandom_range(0, 9) < 3);
            default: out_ready <= (cycle_count[2:0] == 3'd0);
        endcase
    end

    // Monitor: compare each result with the oldest prediction
    always @(posedge clk) begin
        rx_result_t want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_results.size() == 0) begin
                log_failure("result with no request outstanding");
            end else begin
                want = expected_results.pop_front();
                check_field("status", 16'(want.status), 16'(status));
                check_field("endpoint_accepting", 16'(want.ep), 16'(ep_accepting));
                check_field("frame_ready", 16'(want.rdy), 16'(frame_ready));
                check_field("frame_length", 16'(want.len), 16'(frame_length));
                check_field("read_data", 16'(want.rdata), 16'(read_data));
            end
        end
    end

    task automatic push_req(input logic [ACTION_W-1:0] a, input logic [BYTE_W-1:0] d,
                            input logic [IDX_W-1:0] x);
        rx_req_t r;
        r.action = a;
        r.data   = d;
        r.idx    = x;
        pending_reqs.push_back(r);
        reqs_made++;
        if (a == ACT_PKT_BYTE)
            pkt_open = 1'b1;
        else if (a == ACT_PKT_END || a == ACT_RESET)
            pkt_open = 1'b0;
    endtask

    // Request whose byte and index fields are don't-care
    task automatic push_op(input logic [ACTION_W-1:0] a);
        push_req(a, BYTE_W'($urandom), IDX_W'($urandom));
    endtask

    task automatic send_packet(input int nbytes);
        for (int i = 0; i < nbytes; i++)
            push_op(ACT_PKT_BYTE);
        push_op(ACT_PKT_END);
    endtask

    // Full packets (optionally oversize), then a short or zero-length one
    task automatic send_frame(input int len, input bit oversize);
        int rem;
        rem = len;
        while (rem >= MAX_PKT) begin
            send_packet(MAX_PKT + ((oversize && $urandom_range(0, 1)) ? $urandom_range(1, 4) : 0));
            rem -= MAX_PKT;
        end
        send_packet(rem);
        last_frame_len = len;
    endtask

    task automatic read_some(input int len, input int n);
        int sel;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(0, 99);
            if (len > 0 && sel < 70)
                push_req(ACT_READ, BYTE_W'($urandom), IDX_W'($urandom_range(0, len - 1)));
            else if (sel < 85)
                push_req(ACT_READ, BYTE_W'($urandom), IDX_W'(len + $urandom_range(0, 2)));
            else
                push_op(ACT_READ);
        end
    endtask

    // Block until no request is queued, in flight or awaiting its result
    task automatic wait_idle();
        while (pending_reqs.size() != 0 || expected_results.size() != 0 || in_valid)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_iface(input bit v);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        iface_en = v;
    endtask

    task automatic random_traffic(input int n);
        int target;
        int sel;
        int len;
        target = reqs_made + n;
        while (reqs_made < target) begin
            sel = $urandom_range(0, 99);
            if (sel < 60) begin
                // well-formed frame, read back, usually released
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: len = $urandom_range(1, MAX_PKT - 1);
                    6, 7:             len = $urandom_range(MAX_PKT, 300);
                    8:                len = MAX_PKT * $urandom_range(1, 3);
                    default:          len = 0;
                endcase
                send_frame(len, $urandom_range(0, 4) == 0);
                if ($urandom_range(0, 5) == 0)
                    send_packet($urandom_range(0, 10));
                read_some(len, $urandom_range(1, 6));
                if ($urandom_range(0, 9) != 0)
                    push_op(ACT_RELEASE);
            end else if (sel < 75) begin
                // stray reads and releases; no release inside an open packet
                repeat ($urandom_range(1, 4)) begin
                    if (!pkt_open && $urandom_range(0, 2) == 0)
                        push_op(ACT_RELEASE);
                    else
                        read_some(last_frame_len, 1);
                end
            end else if (sel < 88) begin
                // partial packet: cut by a state reset, left open, or closed
                repeat ($urandom_range(1, MAX_PKT + 6))
                    push_op(ACT_PKT_BYTE);
                case ($urandom_range(0, 2))
                    0:       push_op(ACT_RESET);
                    1:       ;
                    default: push_op(ACT_PKT_END);
                endcase
            end else begin
                case ($urandom_range(0, 2))
                    0:       push_op(ACT_RESET);
                    1:       push_op(ACT_PKT_END);
                    default: push_op(ACTION_W'($urandom_range(ACT_SPARE_5, ACT_SPARE_7)));
                endcase
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: interface still disabled after reset
        push_op(ACT_RELEASE);
        push_req(ACT_READ, BYTE_W'($urandom), {IDX_W{1'b1}});
        push_op(ACT_RESET);

        // Directed: interface enabled
        write_iface(1'b1);
        push_op(ACT_RESET);
        push_op(ACT_PKT_END);
        push_req(ACT_PKT_BYTE, 8'h00, IDX_W'($urandom));
        push_req(ACT_PKT_BYTE, 8'hFF, IDX_W'($urandom));
        push_req(ACT_PKT_BYTE, 8'hA5, IDX_W'($urandom));
        push_op(ACT_PKT_END);
        push_req(ACT_READ, BYTE_W'($urandom), IDX_W'(0));
        push_req(ACT_READ, BYTE_W'($urandom), IDX_W'(2));
        push_req(ACT_READ, BYTE_W'($urandom), IDX_W'(3));
        push_req(ACT_READ, BYTE_W'($urandom), {IDX_W{1'b1}});
        send_packet(2);
        push_op(ACT_RELEASE);
        push_op(ACT_RELEASE);
        push_op(ACT_SPARE_5);
        push_op(ACT_SPARE_7);

        // Packet size boundary: oversize packet folded into a short frame
        write_iface(1'b1);
        send_packet(MAX_PKT + 6);
        send_packet(5);
        push_req(ACT_READ, BYTE_W'($urandom), IDX_W'(MAX_PKT + 4));
        push_req(ACT_READ, BYTE_W'($urandom), IDX_W'(MAX_PKT + 5));
        push_op(ACT_RELEASE);
        send_frame(10, 1'b0);
        read_some(10, 3);
        push_op(ACT_RELEASE);

        // Random traffic, interface setting toggled between phases
        for (int p = 0; p < 5; p++) begin
            write_iface(p % 2 == 1);
            random_traffic(RANDOM_REQS);
        end

        wait_idle();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> sim.f
design/ecm_rx_pkg.sv
design/ecm_rx_store.sv
design/ecm_rx_ctrl.sv
design/usb_ecm_rx_frame_reassembler_core.sv
tb/testbench.sv
